FILE: rtl/qdlp_pkg.sv
`timescale 1ns / 1ps

package qdlp_pkg;

   // Default for the per-list item limit
   localparam int DEF_MAX_ITEMS = 16;

   // Result field widths
   localparam int KIND_W   = 2;
   localparam int INDEX_W  = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   // Section codes
   localparam logic [2:0] SEC_BEFORE  = 3'd0;
   localparam logic [2:0] SEC_DIST    = 3'd1;
   localparam logic [2:0] SEC_BETWEEN = 3'd2;
   localparam logic [2:0] SEC_IDS     = 3'd3;
   localparam logic [2:0] SEC_AFTER   = 3'd4;

   // Number scanner phases
   localparam logic [1:0] PH_BLANKS = 2'd0;
   localparam logic [1:0] PH_DIGITS = 2'd1;
   localparam logic [1:0] PH_STOP   = 2'd2;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_DIST   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ID     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_COUNT_DIFF = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_BRACKET = 2'd2;

   // Characters
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_OPEN   = 8'h5B;
   localparam logic [7:0] CH_CLOSE  = 8'h5D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   // Output queue geometry
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   // One result item
   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [INDEX_W-1:0]  index;
      logic [VALUE_W-1:0]  value;
      logic [STATUS_W-1:0] status;
      logic                last;
   } result_type;

endpackage

FILE: rtl/quoted_decimal_list_parser.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  text_byte, end_of_text
// rsp_      out        rsp_valid / rsp_ready  result_kind, item_index, item_value,
//                                             parse_status, last_result
//
// One byte is taken per cycle; its results (up to two) enter a four-entry output
// queue in the same edge and leave one per cycle while rsp_ready is high, the first
// in the cycle after its byte. req_ready is high while the queue has room for two
// results, so a byte is taken every cycle as long as the consumer keeps up.
// Reset is synchronous and active high; the parser is at the start of a report.
// A stalled rsp_ready fills the queue; with three results waiting req_ready drops.
module quoted_decimal_list_parser #(
   parameter int MAX_ITEMS = qdlp_pkg::DEF_MAX_ITEMS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_text_byte,
   input  logic                           req_end_of_text,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [qdlp_pkg::KIND_W-1:0]    rsp_result_kind,
   output logic [qdlp_pkg::INDEX_W-1:0]   rsp_item_index,
   output logic signed [qdlp_pkg::VALUE_W-1:0] rsp_item_value,
   output logic [qdlp_pkg::STATUS_W-1:0]  rsp_parse_status,
   output logic                           rsp_last_result
);

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

   // Parser state
   logic [2:0]                      section_ff, section_in;
   logic                            quote_ff, quote_in;
   logic [1:0]                      phase_ff, phase_in;
   logic                            neg_ff, neg_in;
   logic [qdlp_pkg::VALUE_W-1:0]    acc_ff, acc_in;
   logic [CNT_W-1:0]                dist_cnt_ff, dist_cnt_in;
   logic [CNT_W-1:0]                id_cnt_ff, id_cnt_in;

   // Output queue
   qdlp_pkg::result_type            queue_ff [qdlp_pkg::QDEPTH];
   logic [qdlp_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [qdlp_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [qdlp_pkg::QCNT_W-1:0]     qcnt_ff, qcnt_in;

   logic                            accept;
   logic                            pop;
   logic [7:0]                      c;
   logic                            is_digit;
   logic                            is_blank;
   logic [qdlp_pkg::VALUE_W-1:0]    digit_val;
   logic [qdlp_pkg::VALUE_W-1:0]    value;
   logic                            emit_value;
   logic [qdlp_pkg::KIND_W-1:0]     value_kind;
   logic [CNT_W-1:0]                value_cnt;
   logic [CNT_W+qdlp_pkg::INDEX_W-1:0] value_idx_ext;
   logic [CNT_W+qdlp_pkg::INDEX_W-1:0] count_idx_ext;
   qdlp_pkg::result_type            value_res;
   qdlp_pkg::result_type            status_res;
   qdlp_pkg::result_type            push0;
   logic [1:0]                      num_push;

   // Evaluated before the end-of-text clear takes effect
   logic [2:0]       sec_parsed;
   logic [CNT_W-1:0] dist_parsed;
   logic [CNT_W-1:0] id_parsed;

   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = (qcnt_ff <= qdlp_pkg::QCNT_W'(qdlp_pkg::QDEPTH - 2));

   // Character classes
   assign c         = req_text_byte;
   assign is_digit  = (c >= qdlp_pkg::CH_ZERO) && (c <= qdlp_pkg::CH_NINE);
   assign is_blank  = (c == qdlp_pkg::CH_SPACE) ||
                      ((c >= qdlp_pkg::CH_TAB) && (c <= qdlp_pkg::CH_CR));
   assign digit_val = {{(qdlp_pkg::VALUE_W-4){1'b0}}, c[3:0]};
   assign value     = neg_ff ? (-acc_ff) : acc_ff;

   // Parse one byte: next state and the value result, if any
   always_comb begin
      section_in  = section_ff;
      quote_in    = quote_ff;
      phase_in    = phase_ff;
      neg_in      = neg_ff;
      acc_in      = acc_ff;
      dist_cnt_in = dist_cnt_ff;
      id_cnt_in   = id_cnt_ff;
      emit_value  = 1'b0;
      value_kind  = qdlp_pkg::KIND_DIST;
      value_cnt   = dist_cnt_ff;
      sec_parsed  = section_ff;
      dist_parsed = dist_cnt_ff;
      id_parsed   = id_cnt_ff;

      if (accept) begin
         priority if ((section_ff == qdlp_pkg::SEC_BEFORE) ||
                      (section_ff == qdlp_pkg::SEC_BETWEEN)) begin
            if (c == qdlp_pkg::CH_OPEN) begin
               section_in = section_ff + 3'd1;
               quote_in   = 1'b0;
            end
         end else if ((section_ff == qdlp_pkg::SEC_DIST) ||
                      (section_ff == qdlp_pkg::SEC_IDS)) begin
            priority if (c == qdlp_pkg::CH_CLOSE) begin
               // open item, if any, is dropped
               section_in = section_ff + 3'd1;
               quote_in   = 1'b0;
            end else if (c == qdlp_pkg::CH_QUOTE) begin
               if (!quote_ff) begin
                  quote_in = 1'b1;
                  phase_in = qdlp_pkg::PH_BLANKS;
                  neg_in   = 1'b0;
                  acc_in   = '0;
               end else begin
                  quote_in = 1'b0;
                  if (section_ff == qdlp_pkg::SEC_DIST) begin
                     value_kind = qdlp_pkg::KIND_DIST;
                     value_cnt  = dist_cnt_ff;
                     if (dist_cnt_ff < MAX_CNT) begin
                        emit_value  = 1'b1;
                        dist_cnt_in = dist_cnt_ff + CNT_W'(1);
                     end
                  end else begin
                     value_kind = qdlp_pkg::KIND_ID;
                     value_cnt  = id_cnt_ff;
                     if (id_cnt_ff < MAX_CNT) begin
                        emit_value = 1'b1;
                        id_cnt_in  = id_cnt_ff + CNT_W'(1);
                     end
                  end
               end
            end else if (quote_ff) begin
               // atoi-style number scan
               priority if (phase_ff == qdlp_pkg::PH_BLANKS) begin
                  priority if (is_blank) begin
                     phase_in = phase_ff;
                  end else if ((c == qdlp_pkg::CH_PLUS) || (c == qdlp_pkg::CH_MINUS)) begin
                     neg_in   = (c == qdlp_pkg::CH_MINUS);
                     phase_in = qdlp_pkg::PH_DIGITS;
                  end else if (is_digit) begin
                     acc_in   = digit_val;
                     phase_in = qdlp_pkg::PH_DIGITS;
                  end else begin
                     phase_in = qdlp_pkg::PH_STOP;
                  end
               end else if (phase_ff == qdlp_pkg::PH_DIGITS) begin
                  if (is_digit) begin
                     acc_in = (acc_ff << 3) + (acc_ff << 1) + digit_val;
                  end else begin
                     phase_in = qdlp_pkg::PH_STOP;
                  end
               end else begin
                  phase_in = phase_ff;
               end
            end else begin
               // text between items is ignored
               quote_in = quote_ff;
            end
         end else begin
            section_in = section_ff;
         end

         // State after this byte, as the status sees it
         sec_parsed  = section_in;
         dist_parsed = dist_cnt_in;
         id_parsed   = id_cnt_in;

         // Report end: status, then back to the reset state
         if (req_end_of_text) begin
            section_in  = qdlp_pkg::SEC_BEFORE;
            quote_in    = 1'b0;
            phase_in    = qdlp_pkg::PH_BLANKS;
            neg_in      = 1'b0;
            acc_in      = '0;
            dist_cnt_in = '0;
            id_cnt_in   = '0;
         end
      end
   end

   // Result items built from this byte
   assign value_idx_ext = {{qdlp_pkg::INDEX_W{1'b0}}, value_cnt};

   always_comb begin
      value_res        = '0;
      value_res.kind   = value_kind;
      value_res.index  = value_idx_ext[qdlp_pkg::INDEX_W-1:0];
      value_res.value  = value;
      value_res.status = qdlp_pkg::ST_OK;
      value_res.last   = !req_end_of_text;
   end

   // Status looks at the state after this byte is parsed
   always_comb begin
      status_res      = '0;
      status_res.kind = qdlp_pkg::KIND_STATUS;
      status_res.last = 1'b1;
      count_idx_ext   = {{qdlp_pkg::INDEX_W{1'b0}}, dist_parsed};
      priority if (sec_parsed != qdlp_pkg::SEC_AFTER) begin
         status_res.status = qdlp_pkg::ST_NO_BRACKET;
      end else if (dist_parsed != id_parsed) begin
         status_res.status = qdlp_pkg::ST_COUNT_DIFF;
      end else begin
         status_res.status = qdlp_pkg::ST_OK;
         status_res.index  = count_idx_ext[qdlp_pkg::INDEX_W-1:0];
      end
   end

   assign push0    = emit_value ? value_res : status_res;
   assign num_push = accept ? ({1'b0, emit_value} + {1'b0, req_end_of_text}) : 2'd0;

   // Queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + qdlp_pkg::QPTR_W'(num_push);
      rd_ptr_in = rd_ptr_ff + qdlp_pkg::QPTR_W'(pop);
      qcnt_in   = qcnt_ff + qdlp_pkg::QCNT_W'(num_push) - qdlp_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         section_ff  <= qdlp_pkg::SEC_BEFORE;
         quote_ff    <= 1'b0;
         phase_ff    <= qdlp_pkg::PH_BLANKS;
         neg_ff      <= 1'b0;
         acc_ff      <= '0;
         dist_cnt_ff <= '0;
         id_cnt_ff   <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         qcnt_ff     <= '0;
      end else begin
         section_ff  <= section_in;
         quote_ff    <= quote_in;
         phase_ff    <= phase_in;
         neg_ff      <= neg_in;
         acc_ff      <= acc_in;
         dist_cnt_ff <= dist_cnt_in;
         id_cnt_ff   <= id_cnt_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         qcnt_ff     <= qcnt_in;
      end
   end

   // Queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (num_push != 2'd0) begin
         queue_ff[wr_ptr_ff] <= push0;
      end
      if (num_push == 2'd2) begin
         queue_ff[wr_ptr_ff + qdlp_pkg::QPTR_W'(1)] <= status_res;
      end
   end

   // Result port from queue head
   assign rsp_valid        = (qcnt_ff != '0);
   assign rsp_result_kind  = queue_ff[rd_ptr_ff].kind;
   assign rsp_item_index   = queue_ff[rd_ptr_ff].index;
   assign rsp_item_value   = queue_ff[rd_ptr_ff].value;
   assign rsp_parse_status = queue_ff[rd_ptr_ff].status;
   assign rsp_last_result  = queue_ff[rd_ptr_ff].last;

   // Checks
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      qcnt_ff <= qdlp_pkg::QCNT_W'(qdlp_pkg::QDEPTH))
      else $error("output queue overflow");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (dist_cnt_ff <= MAX_CNT) && (id_cnt_ff <= MAX_CNT))
      else $error("list count above limit");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == qdlp_pkg::KIND_STATUS) |-> rsp_last_result)
      else $error("status item not marked last");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_text |=>
         (section_ff == qdlp_pkg::SEC_BEFORE) && (dist_cnt_ff == '0) && (id_cnt_ff == '0))
      else $error("state not cleared after report end");

endmodule
